FILE: hdl/sfp_pkg.sv
package sfp_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int SPF_W      = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [SPF_W-1:0]  SPF_RESET  = 7'd40;
  localparam logic [BYTE_W-1:0] SYNC_FIRST = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

  // register index taken from paddr[2]
  localparam logic CFG_IDX_SPF = 1'b0;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                first;
    logic                last;
    logic [BYTE_W-1:0]   len_byte;
    logic [BYTE_W-1:0]   csum;
  } sfp_entry_t;

  typedef enum logic [2:0] {
    BS_START,
    BS_SYNC2,
    BS_LEN,
    BS_HI,
    BS_LO,
    BS_CSUM
  } sfp_step_t;

endpackage

FILE: hdl/sfp_sample_if.sv
interface sfp_sample_if;
  logic                         valid;
  logic                         ready;
  logic [sfp_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: hdl/sfp_byte_if.sv
interface sfp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [sfp_pkg::BYTE_W-1:0] frame_byte;
  logic                       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

FILE: hdl/sfp_front.sv
module sfp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sfp_pkg::SPF_W-1:0]   spf,
  sfp_sample_if.sink                  in_ch,
  input  logic                        q_full,
  output logic                        q_push,
  output sfp_pkg::sfp_entry_t         q_entry
);

  logic [sfp_pkg::SPF_W-1:0]  pos_r, pos_nxt;
  logic [sfp_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [sfp_pkg::SPF_W-1:0]  count;
  logic [sfp_pkg::BYTE_W-1:0] base_sum;
  logic [sfp_pkg::BYTE_W-1:0] new_sum;
  logic                       first;
  logic                       last;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    count    = (spf == '0) ? sfp_pkg::SPF_W'(1) : spf;
    first    = (pos_r == '0);
    base_sum = first ? '0 : sum_r;
    new_sum  = base_sum + in_ch.sample[sfp_pkg::BYTE_W-1:0]
             + in_ch.sample[sfp_pkg::SAMPLE_W-1:sfp_pkg::BYTE_W];
    last     = ({1'b0, pos_r} + 8'd1) >= {1'b0, count};

    q_entry.sample   = in_ch.sample;
    q_entry.first    = first;
    q_entry.last     = last;
    q_entry.len_byte = {count, 1'b0};
    q_entry.csum     = new_sum;

    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (q_push) begin
      pos_nxt = last ? '0 : pos_r + sfp_pkg::SPF_W'(1);
      sum_nxt = last ? '0 : new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

FILE: hdl/sfp_queue.sv
module sfp_queue #(
  parameter int DEPTH = sfp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sfp_pkg::sfp_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output sfp_pkg::sfp_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfp_pkg::sfp_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/sfp_back.sv
module sfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sfp_pkg::sfp_entry_t q_head,
  output logic                q_pop,
  sfp_byte_if.source          out_ch
);

  sfp_pkg::sfp_step_t step_r, step_nxt;

  logic                       out_valid_r;
  logic [sfp_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                       out_eof_r, out_eof_nxt;
  logic                       load;
  logic                       advance;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_byte   = out_byte_r;
  assign out_ch.end_of_frame = out_eof_r;

  assign load    = !out_valid_r || out_ch.ready;
  assign advance = load && !q_empty;

  always_comb begin
    step_nxt     = step_r;
    out_byte_nxt = q_head.sample[sfp_pkg::BYTE_W-1:0];
    out_eof_nxt  = 1'b0;
    q_pop        = 1'b0;
    case (step_r)
      sfp_pkg::BS_START: begin
        if (q_head.first) begin
          out_byte_nxt = sfp_pkg::SYNC_FIRST;
          step_nxt     = sfp_pkg::BS_SYNC2;
        end else begin
          step_nxt     = sfp_pkg::BS_HI;
        end
      end
      sfp_pkg::BS_SYNC2: begin
        out_byte_nxt = sfp_pkg::SYNC_SECOND;
        step_nxt     = sfp_pkg::BS_LEN;
      end
      sfp_pkg::BS_LEN: begin
        out_byte_nxt = q_head.len_byte;
        step_nxt     = sfp_pkg::BS_LO;
      end
      sfp_pkg::BS_LO: begin
        step_nxt = sfp_pkg::BS_HI;
      end
      sfp_pkg::BS_HI: begin
        out_byte_nxt = q_head.sample[sfp_pkg::SAMPLE_W-1:sfp_pkg::BYTE_W];
        if (q_head.last) begin
          step_nxt = sfp_pkg::BS_CSUM;
        end else begin
          step_nxt = sfp_pkg::BS_START;
          q_pop    = advance;
        end
      end
      sfp_pkg::BS_CSUM: begin
        out_byte_nxt = q_head.csum;
        out_eof_nxt  = 1'b1;
        step_nxt     = sfp_pkg::BS_START;
        q_pop        = advance;
      end
      default: begin
        step_nxt = sfp_pkg::BS_START;
      end
    endcase
    if (!advance) begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= sfp_pkg::BS_START;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        out_valid_r <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= out_byte_nxt;
      out_eof_r  <= out_eof_nxt;
    end
  end

endmodule

FILE: hdl/sample_frame_packer_unit.sv
// Sample frame packer: takes 16-bit samples and sends a byte stream of frames
// 0xAA, 0x55, length (2 x samples_per_frame), each sample low byte first, then
// the modulo-256 sum of the payload bytes with end_of_frame set. A front stage
// takes one sample per cycle into a small queue while it has room; the back
// stage sends one byte per cycle while the receiver takes it and sets the rate.
// A sample costs two bytes, plus three header bytes for a frame's first sample
// and a checksum byte for its last. The first byte passes the queue and the
// output register. samples_per_frame of 0 acts as 1; a new size applies from
// the next sample on. Write configuration only while the block is idle.
module sample_frame_packer_unit #(
  parameter int QUEUE_DEPTH = sfp_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sfp_sample_if.sink                       in_ch,
  sfp_byte_if.source                       out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sfp_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sfp_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  logic [sfp_pkg::SPF_W-1:0] spf_r;
  logic                      cfg_wr;
  logic                      q_push, q_pop, q_full, q_empty;
  sfp_pkg::sfp_entry_t       q_entry, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                   && (cfg_paddr[2] == sfp_pkg::CFG_IDX_SPF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spf_r <= sfp_pkg::SPF_RESET;
    end else if (cfg_wr) begin
      spf_r <= cfg_pwdata[sfp_pkg::SPF_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == sfp_pkg::CFG_IDX_SPF) begin
      cfg_prdata = {{(sfp_pkg::CFG_DATA_W - sfp_pkg::SPF_W){1'b0}}, spf_r};
    end
  end

  sfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .spf     (spf_r),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  sfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  sfp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: verif/sample_frame_packer_unit_test.sv
`timescale 1ns / 100ps

module sample_frame_packer_unit_test;

  localparam logic [sfp_pkg::CFG_ADDR_W-1:0] ADDR_SPF    = {sfp_pkg::CFG_IDX_SPF, 2'b00};
  localparam logic [sfp_pkg::CFG_ADDR_W-1:0] ADDR_UNUSED = {~sfp_pkg::CFG_IDX_SPF, 2'b00};
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS    = 12;
  localparam int SEG_SAMPLES = 40;

  typedef struct packed {
    logic [sfp_pkg::BYTE_W-1:0] frame_byte;
    logic                       end_of_frame;
  } byte_beat_t;

  class frame_tracker;
    logic [sfp_pkg::SPF_W-1:0]  frame_size;
    logic [sfp_pkg::SPF_W-1:0]  position;
    logic [sfp_pkg::BYTE_W-1:0] checksum;
    byte_beat_t                 expected_beats[$];
    int                         errors;
    int                         beat_count;

    function new();
      frame_size = sfp_pkg::SPF_RESET;
      position   = '0;
      checksum   = '0;
      errors     = 0;
      beat_count = 0;
    endfunction

    function void set_size(logic [sfp_pkg::CFG_ADDR_W-1:0] addr,
                           logic [sfp_pkg::CFG_DATA_W-1:0] data);
      if (addr[2] == sfp_pkg::CFG_IDX_SPF) begin
        frame_size = data[sfp_pkg::SPF_W-1:0];
      end
    endfunction

    function void push_byte(logic [sfp_pkg::BYTE_W-1:0] b, logic eof);
      byte_beat_t beat;
      beat.frame_byte   = b;
      beat.end_of_frame = eof;
      expected_beats.push_back(beat);
    endfunction

    function void note_sample(logic [sfp_pkg::SAMPLE_W-1:0] s);
      logic [sfp_pkg::SPF_W-1:0] size;
      size = (frame_size == '0) ? sfp_pkg::SPF_W'(1) : frame_size;
      if (position == '0) begin
        push_byte(sfp_pkg::SYNC_FIRST, 1'b0);
        push_byte(sfp_pkg::SYNC_SECOND, 1'b0);
        push_byte({size, 1'b0}, 1'b0);
        checksum = '0;
      end
      push_byte(s[7:0], 1'b0);
      push_byte(s[15:8], 1'b0);
      checksum = checksum + s[7:0] + s[15:8];
      if ({1'b0, position} + 8'd1 >= {1'b0, size}) begin
        push_byte(checksum, 1'b1);
        position = '0;
        checksum = '0;
      end else begin
        position = position + sfp_pkg::SPF_W'(1);
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) begin
        $display("ERROR beat %0d: %s", beat_count, msg);
      end
    endfunction

    function void check_byte(logic [sfp_pkg::BYTE_W-1:0] b, logic eof);
      byte_beat_t beat;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat frame_byte %02h end_of_frame %0b", b, eof));
      end else begin
        beat = expected_beats.pop_front();
        if (b !== beat.frame_byte) begin
          report($sformatf("frame_byte exp %02h got %02h", beat.frame_byte, b));
        end
        if (eof !== beat.end_of_frame) begin
          report($sformatf("end_of_frame exp %0b got %0b", beat.end_of_frame, eof));
        end
      end
      beat_count++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [sfp_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [sfp_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [sfp_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  int sender_idle_pct;
  int receiver_stall_pct;
  int cycle_count;

  frame_tracker tracker;

  sfp_sample_if sample_ch();
  sfp_byte_if   byte_ch();

  sample_frame_packer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (sample_ch),
    .out_ch      (byte_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("sample_frame_packer_unit: mismatch");
    $finish;
  end

  // receiver: check accepted beats, randomize ready
  always @(posedge clk) begin
    if (rst_n && byte_ch.valid && byte_ch.ready) begin
      tracker.check_byte(byte_ch.frame_byte, byte_ch.end_of_frame);
    end
    byte_ch.ready <= rst_n && ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  task automatic send_sample(logic [sfp_pkg::SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      sample_ch.valid <= 1'b0;
      sample_ch.sample <= sfp_pkg::SAMPLE_W'($urandom);
      @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    tracker.note_sample(s);
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [sfp_pkg::CFG_ADDR_W-1:0] addr,
                           logic [sfp_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.set_size(addr, data);
    @(posedge clk);
  endtask

  initial begin
    logic [sfp_pkg::CFG_DATA_W-1:0] size_val;
    tracker = new();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst_n            <= 1'b0;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size, open frame
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h00FF);
    send_sample(16'hFF00);
    drain();
    // shrink mid-frame: next sample closes
    write_reg(ADDR_SPF, 32'd5);
    send_sample(16'h8001);
    send_sample(16'h7FFE);
    send_sample(16'h1234);
    send_sample(16'h5A5A);
    drain();
    write_reg(ADDR_SPF, 32'd2);
    send_sample(16'hA5A5);
    drain();
    // zero size via high bits only, acts as one
    write_reg(ADDR_SPF, 32'hFFFF_FF80);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'h0001);
    drain();
    write_reg(ADDR_UNUSED, 32'h0000_0003);
    send_sample(16'hC3C3);
    drain();
    write_reg(ADDR_SPF, 32'h0000_00FF);
    send_sample(16'hFFFF);
    send_sample(16'hFEFE);
    drain();
    write_reg(ADDR_SPF, 32'd1);
    send_sample(16'hFFFF);
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 50;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 50;
        end
        default: begin
          sender_idle_pct = 32;
          receiver_stall_pct = 32;
        end
      endcase
      case (seg)
        0: size_val = 32'd1;
        1: size_val = 32'd127;
        2: size_val = {25'($urandom_range(1, 32'h01FF_FFFF)), 7'd0};
        default: begin
          case ($urandom_range(0, 3))
            0: size_val = $urandom_range(1, 4);
            1: size_val = $urandom_range(1, 16);
            2: size_val = $urandom_range(1, 127);
            default: size_val = $urandom;
          endcase
        end
      endcase
      write_reg(ADDR_SPF, size_val);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(ADDR_UNUSED, $urandom);
      end
      for (int k = 0; k < SEG_SAMPLES; k++) begin
        send_sample(sfp_pkg::SAMPLE_W'($urandom));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_beats.size() == 0) begin
      $display("sample_frame_packer_unit: match");
    end else begin
      $display("sample_frame_packer_unit: mismatch");
    end
    $finish;
  end

endmodule
